@@ hw/rtl/crp_pkg.sv @@
// ----------------------------------------------------------------------------
// crp_pkg: shared types and constants for the clock page replacement block
// Holds the sequencer state type and the fixed hit count width.
// ----------------------------------------------------------------------------
package crp_pkg;

    // Width of the use counter after a hit increment (before aging)
    localparam int unsigned HIT_COUNT_W = 2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SWEEP,
        ST_EVICT,
        ST_DONE
    } t_state;

endpackage

@@ hw/rtl/crp_ram.sv @@
// ----------------------------------------------------------------------------
// crp_ram: generic single-port RAM with registered read
// One write or read address per cycle; read data is registered and appears in the cycle after its address.
// ----------------------------------------------------------------------------
module crp_ram #(
    parameter int unsigned WIDTH = 20,
    parameter int unsigned DEPTH = 8,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/clock_page_replacement.sv @@
// ----------------------------------------------------------------------------
// clock_page_replacement: second-chance (clock) page replacement engine
// Looks up one page reference over a set of frames with a single shared
// comparator, sweeps the clock hand on a miss and reports the outcome.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+-------------------------------
//  in      | to block  | i_valid / o_stall  | i_page_number
//  out     | from block| o_valid / i_stall  | o_hit, o_frame_index,
//          |           |                    | o_evicted_valid, o_evicted_page,
//          |           |                    | o_evicted_count, o_hit_count
//
// One reference is in flight at a time. The page RAM is read one frame per
// cycle through one comparator during lookup: a hit ends the lookup at the
// matching frame, a miss scans every frame, sweeps the hand and fills a frame.
// The result then sits in the output register, held while i_stall is high.
// Reset (synchronous, active low) clears the frame flags and the clock hand
// at once; the page RAM needs no clearing.
// ----------------------------------------------------------------------------
module clock_page_replacement #(
    parameter int unsigned FRAMES    = 8,
    parameter int unsigned PAGE_BITS = 20,
    localparam int unsigned IDX_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [PAGE_BITS-1:0]            i_page_number,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_hit,
    output logic [IDX_W-1:0]                o_frame_index,
    output logic                            o_evicted_valid,
    output logic [PAGE_BITS-1:0]            o_evicted_page,
    output logic                            o_evicted_count,
    output logic [crp_pkg::HIT_COUNT_W-1:0] o_hit_count
);

    localparam logic [IDX_W-1:0] LAST = IDX_W'(FRAMES - 1);

    crp_pkg::t_state r_state, n_state;

    // Frame status flags
    logic [FRAMES-1:0]     r_vld;
    logic [FRAMES-1:0]     r_ref;
    logic [FRAMES-1:0]     r_cnt;
    logic [IDX_W-1:0]      r_hand;

    // Lookup pipeline
    logic [PAGE_BITS-1:0]  r_page;
    logic [IDX_W-1:0]      r_idx;
    logic                  r_issue;
    logic                  r_cmp_on;
    logic [IDX_W-1:0]      r_cmp_idx;

    // Result register
    logic                            r_o_hit;
    logic [IDX_W-1:0]                r_o_frame;
    logic                            r_o_ev_valid;
    logic [PAGE_BITS-1:0]            r_o_ev_page;
    logic                            r_o_ev_count;
    logic [crp_pkg::HIT_COUNT_W-1:0] r_o_hit_count;

    logic                            in_xfer;
    logic                            out_xfer;
    logic                            match;
    logic                            miss;
    logic                            ram_we;
    logic [IDX_W-1:0]                ram_addr;
    logic [PAGE_BITS-1:0]            ram_rdata;
    logic [crp_pkg::HIT_COUNT_W-1:0] hit_cnt;
    logic [IDX_W-1:0]                hand_next;

    // Page store
    crp_ram #(
        .WIDTH (PAGE_BITS),
        .DEPTH (FRAMES)
    ) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (r_page),
        .o_rdata (ram_rdata)
    );

    // Shared comparator and derived strobes
    assign in_xfer   = i_valid && !o_stall;
    assign out_xfer  = o_valid && !i_stall;
    assign match     = r_cmp_on && r_vld[r_cmp_idx] && (ram_rdata == r_page);
    assign miss      = r_cmp_on && (r_cmp_idx == LAST) && !match;
    assign hit_cnt   = crp_pkg::HIT_COUNT_W'(r_cnt[r_cmp_idx]) + 1'b1;
    assign hand_next = (r_hand == LAST) ? '0 : r_hand + 1'b1;
    assign ram_we    = (r_state == crp_pkg::ST_EVICT);
    assign ram_addr  = (r_state == crp_pkg::ST_LOOKUP) ? r_idx : r_hand;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= crp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and handshake outputs
    always_comb begin
        n_state = r_state;
        o_stall = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            crp_pkg::ST_IDLE: begin
                o_stall = 1'b0;
                if (in_xfer) n_state = crp_pkg::ST_LOOKUP;
            end
            crp_pkg::ST_LOOKUP: begin
                if (match) begin
                    n_state = crp_pkg::ST_DONE;
                end else if (miss) begin
                    n_state = crp_pkg::ST_SWEEP;
                end
            end
            crp_pkg::ST_SWEEP: begin
                if (!r_ref[r_hand]) n_state = crp_pkg::ST_EVICT;
            end
            crp_pkg::ST_EVICT: begin
                n_state = crp_pkg::ST_DONE;
            end
            crp_pkg::ST_DONE: begin
                o_valid = 1'b1;
                if (out_xfer) n_state = crp_pkg::ST_IDLE;
            end
            default: begin
                n_state = crp_pkg::ST_IDLE;
            end
        endcase
    end

    // Frame flags, clock hand and lookup pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_ref    <= '0;
            r_cnt    <= '0;
            r_hand   <= '0;
            r_issue  <= 1'b0;
            r_cmp_on <= 1'b0;
        end else begin
            case (r_state)
                crp_pkg::ST_IDLE: begin
                    // Latch the reference and start the scan at frame zero
                    if (in_xfer) begin
                        r_idx    <= '0;
                        r_issue  <= 1'b1;
                        r_cmp_on <= 1'b0;
                    end
                end
                crp_pkg::ST_LOOKUP: begin
                    // Issue one frame read per cycle, compare the one before
                    r_cmp_on  <= r_issue;
                    r_cmp_idx <= r_idx;
                    if (r_issue) begin
                        if (r_idx == LAST) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                    // Hit: mark referenced, bump and age the counters
                    if (match) begin
                        r_ref[r_cmp_idx] <= 1'b1;
                        for (int k = 0; k < FRAMES; k++) begin
                            r_cnt[k] <= hit_cnt[1] && (IDX_W'(k) == r_cmp_idx);
                        end
                    end
                end
                crp_pkg::ST_SWEEP: begin
                    // Give a referenced frame its second chance and advance
                    if (r_ref[r_hand]) begin
                        r_ref[r_hand] <= 1'b0;
                        r_cnt[r_hand] <= 1'b0;
                        r_hand        <= hand_next;
                    end
                end
                crp_pkg::ST_EVICT: begin
                    // Load the new page under the hand and age all counters
                    r_vld[r_hand] <= 1'b1;
                    r_ref[r_hand] <= 1'b1;
                    r_cnt         <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // Reference page and result register
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_page <= i_page_number;
        end
        if (r_state == crp_pkg::ST_LOOKUP && match) begin
            r_o_hit       <= 1'b1;
            r_o_frame     <= r_cmp_idx;
            r_o_ev_valid  <= 1'b0;
            r_o_ev_page   <= '0;
            r_o_ev_count  <= 1'b0;
            r_o_hit_count <= hit_cnt;
        end
        if (r_state == crp_pkg::ST_EVICT) begin
            r_o_hit       <= 1'b0;
            r_o_frame     <= r_hand;
            r_o_ev_valid  <= r_vld[r_hand];
            r_o_ev_page   <= r_vld[r_hand] ? ram_rdata : '0;
            r_o_ev_count  <= r_vld[r_hand] & r_cnt[r_hand];
            r_o_hit_count <= '0;
        end
    end

    assign o_hit           = r_o_hit;
    assign o_frame_index   = r_o_frame;
    assign o_evicted_valid = r_o_ev_valid;
    assign o_evicted_page  = r_o_ev_page;
    assign o_evicted_count = r_o_ev_count;
    assign o_hit_count     = r_o_hit_count;

`ifndef SYNTHESIS
    // A hit never displaces a page
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit) |-> (!o_evicted_valid && o_hit_count != '0))
        else $error("hit result reports an eviction or zero count");

    // A miss reports no hit count
    a_miss_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_hit_count == '0))
        else $error("miss result carries a hit count");

    // The reported frame is resident and referenced
    a_frame_resident: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_vld[o_frame_index] && r_ref[o_frame_index]))
        else $error("reported frame is not resident and referenced");

    // The sweep stops only on an unreferenced frame and then fills it
    a_sweep_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == crp_pkg::ST_SWEEP && !r_ref[r_hand])
            |=> (r_state == crp_pkg::ST_EVICT && $stable(r_hand)))
        else $error("sweep did not fill the frame under the hand");
`endif

endmodule
